>>> rtl/cfmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfmb_pkg
// Shared types and constants of the framed message builder: frame magic,
// CRC-16/MODBUS constants, the type-to-length table and the sequencer states.
// ----------------------------------------------------------------------------
package cfmb_pkg;

  localparam logic [31:0] FRAME_PREAMBLE = 32'hAA55AA55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  NUM_TYPES  = 8'd9;
  localparam logic [3:0]  HDR_BYTES  = 4'd7;

  localparam logic [3:0] IDX_MAGIC0 = 4'd0;
  localparam logic [3:0] IDX_MAGIC1 = 4'd1;
  localparam logic [3:0] IDX_MAGIC2 = 4'd2;
  localparam logic [3:0] IDX_MAGIC3 = 4'd3;
  localparam logic [3:0] IDX_TYPE   = 4'd4;
  localparam logic [3:0] IDX_LEN_LO = 4'd5;
  localparam logic [3:0] IDX_LEN_HI = 4'd6;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  function automatic logic [3:0] type_len(input logic [7:0] t);
    logic [3:0] len;
    case (t)
      8'd0, 8'd1, 8'd2, 8'd3: len = 4'd0;
      8'd4:                   len = 4'd1;
      8'd5, 8'd6, 8'd7, 8'd8: len = 4'd4;
      default:                len = 4'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cfmb_crc_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfmb_crc_unit
// Bytewise CRC-16/MODBUS update: folds one byte into the running CRC using
// the reflected polynomial, eight bit steps per byte.
// ----------------------------------------------------------------------------
module cfmb_crc_unit
  import cfmb_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int j = 0; j < 8; j++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

>>> rtl/crc_framed_message_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_framed_message_builder
// Turns one message request into a CRC-16/MODBUS protected byte frame.
// ----------------------------------------------------------------------------
// Each accepted request is checked against the type length table; a bad type
// or a size mismatch is dropped in the accept cycle. A good request becomes a
// frame of 9, 10 or 13 bytes (magic, type, length, payload, CRC low then high)
// sent one byte per cycle unless out_stall holds it, last_byte marking the final
// CRC byte. The byte counter and the bytewise CRC unit are shared by every
// frame byte, so a new request is accepted only once the previous frame is
// done; in_stall is high while a frame is in flight.
// ----------------------------------------------------------------------------
module crc_framed_message_builder
  import cfmb_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  msg_type,
  input  wire logic [31:0] payload_word,
  input  wire logic [7:0]  payload_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_byte,
  output logic [3:0]       byte_index,
  output logic             last_byte
);

  state_t      state;
  logic [7:0]  type_reg;
  logic [31:0] payload;
  logic [3:0]  plen;
  logic [3:0]  idx;
  logic [15:0] crc;
  logic [15:0] crc_next;

  logic [3:0] in_len;
  logic       in_ok;
  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] crc_lo_idx;
  logic [3:0] pay_idx;

  assign in_len  = type_len(msg_type);
  assign in_ok   = (msg_type < NUM_TYPES) && (payload_size == {4'd0, in_len})
                   && (int'(in_len) <= MAX_PAYLOAD_BYTES);
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid  = (state == ST_SEND);
  assign out_xfer   = out_valid && !out_stall;
  assign crc_lo_idx = HDR_BYTES + plen;
  assign pay_idx    = idx - HDR_BYTES;
  assign byte_index = idx;
  assign last_byte  = (idx == crc_lo_idx + 4'd1);

  always_comb begin
    case (idx)
      IDX_MAGIC0: frame_byte = FRAME_PREAMBLE[7:0];
      IDX_MAGIC1: frame_byte = FRAME_PREAMBLE[15:8];
      IDX_MAGIC2: frame_byte = FRAME_PREAMBLE[23:16];
      IDX_MAGIC3: frame_byte = FRAME_PREAMBLE[31:24];
      IDX_TYPE:   frame_byte = type_reg;
      IDX_LEN_LO: frame_byte = {4'd0, plen};
      IDX_LEN_HI: frame_byte = 8'h00;
      default: begin
        if (idx == crc_lo_idx) begin
          frame_byte = crc[7:0];
        end else if (idx == crc_lo_idx + 4'd1) begin
          frame_byte = crc[15:8];
        end else if (pay_idx < 4'd4) begin
          frame_byte = payload[{pay_idx[1:0], 3'b000} +: 8];
        end else begin
          frame_byte = 8'h00;
        end
      end
    endcase
  end

  cfmb_crc_unit u_crc (
    .crc_in  (crc),
    .data    (frame_byte),
    .crc_out (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= 4'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && in_ok) begin
            state <= ST_SEND;
            idx   <= 4'd0;
          end
        end
        ST_SEND: begin
          if (out_xfer) begin
            idx <= idx + 4'd1;
            if (last_byte) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      type_reg <= msg_type;
      payload  <= payload_word;
      plen     <= in_len;
      crc      <= CRC_INIT;
    end else if (out_xfer && (idx < crc_lo_idx)) begin
      crc <= crc_next;
    end
  end

  a_stall_tracks_frame: assert property (@(posedge clk) disable iff (rst)
    in_stall == out_valid)
    else $error("input stall does not match frame in flight");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx <= crc_lo_idx + 4'd1))
    else $error("byte counter beyond end of frame");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_byte) |=> !out_valid)
    else $error("frame continues after last byte");

  a_drop_bad_item: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !in_ok) |=> !out_valid)
    else $error("rejected request produced a frame");

  a_frame_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_ok) |=> (out_valid && idx == 4'd0 && crc == CRC_INIT))
    else $error("frame did not start cleanly");

  a_crc_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(crc) && $stable(idx))
    else $error("frame state moved while stalled");

endmodule
`default_nettype wire
